// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, idle during reset.
`define LCGR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, idle during reset.
`define LCGR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/lcgr_pkg.sv
// Shared types, constants and controller/datapath interface of the cost grid rasteriser.
package lcgr_pkg;

	localparam int GRID_W_DEF           = 128;
	localparam int GRID_H_DEF           = 128;
	localparam int MAX_RADIUS_CELLS_DEF = 8;
	localparam int EGO_CLEAR_CELLS_DEF  = 9;
	localparam int CLEAR_VAL_DEF        = 0;
	localparam int UNSEEN_VAL_DEF       = -1;

	localparam int CELL_W     = 8;   // stored cell width
	localparam int CW         = 20;  // signed cell coordinate width
	localparam int DXW        = 7;   // signed disk offset width (radius up to 63)
	localparam int RADW       = 6;   // disk radius width
	localparam int DIV_W      = 25;  // divider dividend / quotient width
	localparam int DVS_W      = 18;  // divider divisor width
	localparam int SQRT_STEPS = 16;
	localparam int ITER_W     = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		KIND_FILL  = 2'd0,
		KIND_POINT = 2'd1,
		KIND_EGO   = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CELL_SIZE  = 3'd0,
		REG_ORIGIN_X   = 3'd1,
		REG_ORIGIN_Y   = 3'd2,
		REG_COST_NEAR  = 3'd3,
		REG_COST_FAR   = 3'd4,
		REG_MIN_COST   = 3'd5,
		REG_MAX_COST   = 3'd6,
		REG_OBST_RAD   = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_INIT_SWEEP,
		ST_IDLE,
		ST_DISPATCH,
		ST_FILL,
		ST_SQRT_INIT,
		ST_SQRT,
		ST_COST_A,
		ST_COST_B,
		ST_DIVC_INIT,
		ST_DIVC,
		ST_DIVC_END,
		ST_DIVX,
		ST_DIVX_END,
		ST_DIVY,
		ST_DIVY_END,
		ST_WALK_INIT,
		ST_WALK,
		ST_RMW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic latch;
		logic square;
		logic sqrt_init;
		logic sqrt_step;
		logic cost_a;
		logic cost_b;
		logic div_cost_init;
		logic div_x_init;
		logic div_y_init;
		logic div_step;
		logic div_cost_end;
		logic div_x_end;
		logic div_y_end;
		logic walk_init;
		logic walk_adv;
		logic mem_rd_cell;
		logic mem_wr_mark;
		logic mem_wr_clear;
		logic mem_rd_read;
		logic sweep_init;
		logic sweep_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  iter_last;
		logic  sweep_last;
		logic  walk_last;
		logic  cell_hit;
		logic  out_busy;
	} status_t;

endpackage

// File: rtl/lidar_cost_grid_rasterizer_top.sv
// Cost grid rasteriser: one request in, one result out, grid held in a single RAM.
// Requests are taken one at a time. After reset the grid is swept to the unknown value,
// one cell per cycle, before the first request is taken; configuration writes are taken
// at any time. A fill request sweeps the grid to the fill value in the same way, and a
// read fetches one cell. A point runs a 16-step square root, the squaring and two cost
// products and three 25-step shared divisions (cost, x cell, y cell), then walks the
// (2R+1)^2 disk offsets at one per cycle, held for a RAM read on every disk cell that
// lies in the grid, and then loads the result. Ego clear runs the two cell divisions,
// then walks its disk offsets at one per cycle.
// A finished result waits in the output register while the next request is taken; the
// load of the following result stalls until that one has been taken.
module lidar_cost_grid_rasterizer_top #(
	parameter int GRID_W           = lcgr_pkg::GRID_W_DEF,
	parameter int GRID_H           = lcgr_pkg::GRID_H_DEF,
	parameter int MAX_RADIUS_CELLS = lcgr_pkg::MAX_RADIUS_CELLS_DEF,
	parameter int EGO_CLEAR_CELLS  = lcgr_pkg::EGO_CLEAR_CELLS_DEF,
	parameter int CLEAR_VAL        = lcgr_pkg::CLEAR_VAL_DEF,
	parameter int UNSEEN_VAL       = lcgr_pkg::UNSEEN_VAL_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lcgr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcgr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      kind,
	input  logic signed [15:0]              point_x,
	input  logic signed [15:0]              point_y,
	input  logic [13:0]                     cell_index,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [7:0]               cell_value,
	output logic [6:0]                      point_cost,
	output logic                            point_in_grid
);

	lcgr_pkg::cmd_t    cmd;
	lcgr_pkg::status_t sts;

	assign cfg_ready = 1'b1;

	lcgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lcgr_dp #(
		.GRID_W           (GRID_W),
		.GRID_H           (GRID_H),
		.MAX_RADIUS_CELLS (MAX_RADIUS_CELLS),
		.EGO_CLEAR_CELLS  (EGO_CLEAR_CELLS),
		.CLEAR_VAL        (CLEAR_VAL),
		.UNSEEN_VAL       (UNSEEN_VAL)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.kind          (kind),
		.point_x       (point_x),
		.point_y       (point_y),
		.cell_index    (cell_index),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cell_value    (cell_value),
		.point_cost    (point_cost),
		.point_in_grid (point_in_grid)
	);

endmodule

// File: rtl/lcgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lcgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/lcgr_ctrl.sv
// Sequencing state machine of the cost grid rasteriser.
module lcgr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lcgr_pkg::status_t sts,
	output lcgr_pkg::cmd_t    cmd
);

	lcgr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcgr_pkg::ST_INIT_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			lcgr_pkg::ST_INIT_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) state_d = lcgr_pkg::ST_IDLE;
			end
			lcgr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = lcgr_pkg::ST_DISPATCH;
				end
			end
			lcgr_pkg::ST_DISPATCH: begin
				case (sts.kind)
					lcgr_pkg::KIND_FILL: begin
						cmd.sweep_init = 1'b1;
						state_d        = lcgr_pkg::ST_FILL;
					end
					lcgr_pkg::KIND_POINT: begin
						cmd.square = 1'b1;
						state_d    = lcgr_pkg::ST_SQRT_INIT;
					end
					lcgr_pkg::KIND_EGO: begin
						cmd.div_x_init = 1'b1;
						state_d        = lcgr_pkg::ST_DIVX;
					end
					default: begin
						cmd.mem_rd_read = 1'b1;
						state_d         = lcgr_pkg::ST_DONE;
					end
				endcase
			end
			lcgr_pkg::ST_FILL: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) state_d = lcgr_pkg::ST_DONE;
			end
			lcgr_pkg::ST_SQRT_INIT: begin
				cmd.sqrt_init = 1'b1;
				state_d       = lcgr_pkg::ST_SQRT;
			end
			lcgr_pkg::ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.iter_last) state_d = lcgr_pkg::ST_COST_A;
			end
			lcgr_pkg::ST_COST_A: begin
				cmd.cost_a = 1'b1;
				state_d    = lcgr_pkg::ST_COST_B;
			end
			lcgr_pkg::ST_COST_B: begin
				cmd.cost_b = 1'b1;
				state_d    = lcgr_pkg::ST_DIVC_INIT;
			end
			lcgr_pkg::ST_DIVC_INIT: begin
				cmd.div_cost_init = 1'b1;
				state_d           = lcgr_pkg::ST_DIVC;
			end
			lcgr_pkg::ST_DIVC: begin
				cmd.div_step = 1'b1;
				if (sts.iter_last) state_d = lcgr_pkg::ST_DIVC_END;
			end
			lcgr_pkg::ST_DIVC_END: begin
				cmd.div_cost_end = 1'b1;
				cmd.div_x_init   = 1'b1;
				state_d          = lcgr_pkg::ST_DIVX;
			end
			lcgr_pkg::ST_DIVX: begin
				cmd.div_step = 1'b1;
				if (sts.iter_last) state_d = lcgr_pkg::ST_DIVX_END;
			end
			lcgr_pkg::ST_DIVX_END: begin
				cmd.div_x_end  = 1'b1;
				cmd.div_y_init = 1'b1;
				state_d        = lcgr_pkg::ST_DIVY;
			end
			lcgr_pkg::ST_DIVY: begin
				cmd.div_step = 1'b1;
				if (sts.iter_last) state_d = lcgr_pkg::ST_DIVY_END;
			end
			lcgr_pkg::ST_DIVY_END: begin
				cmd.div_y_end = 1'b1;
				state_d       = lcgr_pkg::ST_WALK_INIT;
			end
			lcgr_pkg::ST_WALK_INIT: begin
				cmd.walk_init = 1'b1;
				state_d       = lcgr_pkg::ST_WALK;
			end
			lcgr_pkg::ST_WALK: begin
				if (sts.cell_hit && sts.kind == lcgr_pkg::KIND_POINT) begin
					cmd.mem_rd_cell = 1'b1;
					state_d         = lcgr_pkg::ST_RMW;
				end else begin
					cmd.mem_wr_clear = sts.cell_hit;
					cmd.walk_adv     = 1'b1;
					if (sts.walk_last) state_d = lcgr_pkg::ST_DONE;
				end
			end
			lcgr_pkg::ST_RMW: begin
				cmd.mem_wr_mark = 1'b1;
				cmd.walk_adv    = 1'b1;
				state_d = sts.walk_last ? lcgr_pkg::ST_DONE : lcgr_pkg::ST_WALK;
			end
			lcgr_pkg::ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = lcgr_pkg::ST_IDLE;
				end
			end
			default: state_d = lcgr_pkg::ST_IDLE;
		endcase
	end

endmodule

// File: rtl/lcgr_dp.sv
// Datapath: config registers, square root, shared divider, cell walker, grid RAM and output register.
module lcgr_dp #(
	parameter int GRID_W           = lcgr_pkg::GRID_W_DEF,
	parameter int GRID_H           = lcgr_pkg::GRID_H_DEF,
	parameter int MAX_RADIUS_CELLS = lcgr_pkg::MAX_RADIUS_CELLS_DEF,
	parameter int EGO_CLEAR_CELLS  = lcgr_pkg::EGO_CLEAR_CELLS_DEF,
	parameter int CLEAR_VAL        = lcgr_pkg::CLEAR_VAL_DEF,
	parameter int UNSEEN_VAL       = lcgr_pkg::UNSEEN_VAL_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [lcgr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lcgr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [1:0]                          kind,
	input  logic signed [15:0]                  point_x,
	input  logic signed [15:0]                  point_y,
	input  logic [13:0]                         cell_index,
	input  lcgr_pkg::cmd_t                      cmd,
	output lcgr_pkg::status_t                   sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [7:0]                   cell_value,
	output logic [6:0]                          point_cost,
	output logic                                point_in_grid
);

	localparam int NCELLS = GRID_W * GRID_H;
	localparam int AW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
	localparam int FILL_VALUE = (UNSEEN_VAL >= -1 && UNSEEN_VAL <= 100) ?
		UNSEEN_VAL : CLEAR_VAL;
	localparam int CW   = lcgr_pkg::CW;
	localparam int DXW  = lcgr_pkg::DXW;
	localparam int RADW = lcgr_pkg::RADW;
	localparam int DW   = lcgr_pkg::DIV_W;
	localparam int VW   = lcgr_pkg::DVS_W;

	// configuration
	logic [9:0]         cell_size_q;
	logic signed [15:0] org_x_q, org_y_q;
	logic [15:0]        near_q, far_q;
	logic [6:0]         cost_lo_q, cost_hi_q;
	logic [3:0]         obst_rad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= 10'd100;
			org_x_q     <= -16'sd8000;
			org_y_q     <= -16'sd8000;
			near_q      <= 16'd400;
			far_q       <= 16'd8000;
			cost_lo_q   <= 7'd35;
			cost_hi_q   <= 7'd100;
			obst_rad_q  <= 4'd2;
		end else if (cfg_valid) begin
			case (lcgr_pkg::reg_idx_t'(cfg_index))
				lcgr_pkg::REG_CELL_SIZE: cell_size_q <= cfg_data[9:0];
				lcgr_pkg::REG_ORIGIN_X:  org_x_q     <= $signed(cfg_data);
				lcgr_pkg::REG_ORIGIN_Y:  org_y_q     <= $signed(cfg_data);
				lcgr_pkg::REG_COST_NEAR: near_q      <= cfg_data;
				lcgr_pkg::REG_COST_FAR:  far_q       <= cfg_data;
				lcgr_pkg::REG_MIN_COST:  cost_lo_q   <= cfg_data[6:0];
				lcgr_pkg::REG_MAX_COST:  cost_hi_q   <= cfg_data[6:0];
				lcgr_pkg::REG_OBST_RAD:  obst_rad_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// latched request
	lcgr_pkg::kind_t    kind_q;
	logic signed [15:0] px_q, py_q;
	logic [13:0]        ci_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= lcgr_pkg::KIND_FILL;
		end else if (cmd.latch) begin
			kind_q <= lcgr_pkg::kind_t'(kind);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			px_q <= point_x;
			py_q <= point_y;
			ci_q <= cell_index;
		end
	end

	// squares and square root, one result bit per step
	logic signed [31:0] sqx_s1, sqy_s1;
	logic [31:0]        sq_n_q, sq_res_q, sq_bit_q, sq_sum;
	logic [lcgr_pkg::ITER_W-1:0] iter_q;
	logic               sqrt_mode_q;

	assign sq_sum = sq_res_q + sq_bit_q;

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sqx_s1 <= px_q * px_q;
			sqy_s1 <= py_q * py_q;
		end
		if (cmd.sqrt_init) begin
			sq_n_q   <= $unsigned(sqx_s1) + $unsigned(sqy_s1);
			sq_res_q <= '0;
			sq_bit_q <= 32'd1 << 30;
		end else if (cmd.sqrt_step) begin
			if (sq_n_q >= sq_sum) begin
				sq_n_q   <= sq_n_q - sq_sum;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	// cost ramp terms
	logic [16:0] near17, far_eff, dist_d, r17, far_minus_r;
	logic signed [7:0] cost_delta;
	logic [23:0] prod_a_q;
	logic signed [25:0] prod_b_q;
	logic near_flag_q, far_flag_q;
	logic signed [26:0] num27;
	logic [DW-1:0] cost_dvd;

	assign near17      = {1'b0, near_q};
	assign far_eff     = ({1'b0, far_q} < near17 + 17'd1) ? near17 + 17'd1 : {1'b0, far_q};
	assign dist_d      = far_eff - near17;
	assign r17         = {1'b0, sq_res_q[15:0]};
	assign far_minus_r = far_eff - r17;
	assign cost_delta  = $signed({1'b0, cost_hi_q}) - $signed({1'b0, cost_lo_q});
	assign num27       = $signed({3'b000, prod_a_q}) + {prod_b_q[25], prod_b_q};
	assign cost_dvd    = {num27[23:0], 1'b0} + {8'd0, dist_d};

	always_ff @(posedge clk) begin
		if (cmd.cost_a) begin
			prod_a_q    <= {17'd0, cost_lo_q} * {7'd0, dist_d};
			near_flag_q <= r17 <= near17;
			far_flag_q  <= r17 >= far_eff;
		end
		if (cmd.cost_b) begin
			prod_b_q <= $signed({1'b0, far_minus_r}) * cost_delta;
		end
	end

	// shared restoring divider, one quotient bit per step
	logic [DW-1:0]  dvd_q, quo_q;
	logic [VW-1:0]  rem_q, dvs_q;
	logic [VW:0]    div_t;
	logic           div_ge, neg_q;
	logic [9:0]     cs_eff;
	logic signed [15:0] cell_p, cell_o;
	logic signed [16:0] cell_a;
	logic [16:0]    cell_mag;
	logic [VW-1:0]  cell_dvd;
	logic signed [CW-1:0] quo_s, cx_q, cy_q;
	logic [6:0]     cost_q;

	assign div_t    = {rem_q, dvd_q[DW-1]};
	assign div_ge   = div_t >= {1'b0, dvs_q};
	assign cs_eff   = (cell_size_q == 10'd0) ? 10'd1 : cell_size_q;
	assign cell_p   = cmd.div_y_init ? py_q : px_q;
	assign cell_o   = cmd.div_y_init ? org_y_q : org_x_q;
	// ego clear places the base itself, so its coordinate is zero
	assign cell_a   = ((kind_q == lcgr_pkg::KIND_EGO) ? 17'sd0 : {cell_p[15], cell_p})
		- {cell_o[15], cell_o};
	assign cell_mag = cell_a[16] ? $unsigned(-cell_a) : $unsigned(cell_a);
	// floor for negatives: ceil of the magnitude, negated
	assign cell_dvd = cell_a[16] ? {1'b0, cell_mag} + {8'd0, cs_eff} - 18'd1 : {1'b0, cell_mag};
	assign quo_s    = $signed(quo_q[CW-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.div_cost_init) begin
			dvd_q <= cost_dvd;
			dvs_q <= {dist_d, 1'b0};
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_x_init || cmd.div_y_init) begin
			dvd_q <= {{(DW-VW){1'b0}}, cell_dvd};
			dvs_q <= {8'd0, cs_eff};
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= cell_a[16];
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? VW'(div_t - {1'b0, dvs_q}) : div_t[VW-1:0];
			quo_q <= {quo_q[DW-2:0], div_ge};
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
		end
		if (cmd.div_cost_end) begin
			cost_q <= near_flag_q ? cost_hi_q : (far_flag_q ? cost_lo_q : quo_q[6:0]);
		end
		if (cmd.div_x_end) cx_q <= neg_q ? -quo_s : quo_s;
		if (cmd.div_y_end) cy_q <= neg_q ? -quo_s : quo_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q      <= '0;
			sqrt_mode_q <= 1'b0;
		end else if (cmd.sqrt_init) begin
			iter_q      <= '0;
			sqrt_mode_q <= 1'b1;
		end else if (cmd.div_cost_init || cmd.div_x_init || cmd.div_y_init) begin
			iter_q      <= '0;
			sqrt_mode_q <= 1'b0;
		end else if (cmd.sqrt_step || cmd.div_step) begin
			iter_q <= iter_q + 1'b1;
		end
	end

	assign sts.iter_last = sqrt_mode_q ? (iter_q == lcgr_pkg::ITER_W'(lcgr_pkg::SQRT_STEPS - 1))
		: (iter_q == lcgr_pkg::ITER_W'(DW - 1));

	// disk walker
	logic [RADW-1:0] rad_q, rad_pick;
	logic signed [DXW-1:0] dx_q, dy_q, rad_s;
	logic signed [2*DXW-1:0] dxx, dyy;
	logic [2*DXW:0]  dsq, rsq, rad_w;
	logic signed [CW-1:0] gx, gy;
	logic in_disk, gx_ok, gy_ok, ego_off, cx_ok, cy_ok;
	logic [AW-1:0] walk_idx;

	assign rad_pick = (kind_q == lcgr_pkg::KIND_EGO) ? RADW'(EGO_CLEAR_CELLS) :
		(({2'b00, obst_rad_q} > RADW'(MAX_RADIUS_CELLS)) ? RADW'(MAX_RADIUS_CELLS)
		: {2'b00, obst_rad_q});
	assign rad_s   = $signed({1'b0, rad_q});
	assign dxx     = dx_q * dx_q;
	assign dyy     = dy_q * dy_q;
	assign dsq     = {1'b0, $unsigned(dxx)} + {1'b0, $unsigned(dyy)};
	assign rad_w   = {{(2*DXW+1-RADW){1'b0}}, rad_q};
	assign rsq     = rad_w * rad_w;
	assign in_disk = dsq <= rsq;
	assign gx      = cx_q + CW'(dx_q);
	assign gy      = cy_q + CW'(dy_q);
	assign gx_ok   = !gx[CW-1] && (gx < CW'(GRID_W));
	assign gy_ok   = !gy[CW-1] && (gy < CW'(GRID_H));
	assign cx_ok   = !cx_q[CW-1] && (cx_q < CW'(GRID_W));
	assign cy_ok   = !cy_q[CW-1] && (cy_q < CW'(GRID_H));
	assign ego_off = (kind_q == lcgr_pkg::KIND_EGO) && (EGO_CLEAR_CELLS == 0);
	assign walk_idx = AW'($unsigned(gy)) * AW'(GRID_W) + AW'($unsigned(gx));

	assign sts.cell_hit  = in_disk && gx_ok && gy_ok && !ego_off;
	assign sts.walk_last = (dx_q == rad_s) && (dy_q == rad_s);
	assign sts.kind      = kind_q;

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			rad_q <= rad_pick;
			dx_q  <= -$signed({1'b0, rad_pick});
			dy_q  <= -$signed({1'b0, rad_pick});
		end else if (cmd.walk_adv) begin
			if (dx_q == rad_s) begin
				dx_q <= -rad_s;
				dy_q <= dy_q + 1'b1;
			end else begin
				dx_q <= dx_q + 1'b1;
			end
		end
	end

	// sweep over the whole grid: after reset and for fill requests
	logic [AW-1:0] sw_addr_q;
	logic [7:0]    sw_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_addr_q <= '0;
			sw_val_q  <= 8'(UNSEEN_VAL);
		end else if (cmd.sweep_init) begin
			sw_addr_q <= '0;
			sw_val_q  <= 8'(FILL_VALUE);
		end else if (cmd.sweep_step) begin
			sw_addr_q <= sw_addr_q + 1'b1;
		end
	end

	assign sts.sweep_last = sw_addr_q == AW'(NCELLS - 1);

	// grid memory
	logic          wr_en, rd_en, mark_wr;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0]    wr_data, rd_data;

	// negative cells always take the cost, otherwise keep the larger
	assign mark_wr = rd_data[7] || (cost_q > rd_data[6:0]);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = walk_idx;
		wr_data = {1'b0, cost_q};
		if (cmd.sweep_step) begin
			wr_en   = 1'b1;
			wr_addr = sw_addr_q;
			wr_data = sw_val_q;
		end else if (cmd.mem_wr_clear) begin
			wr_en   = 1'b1;
			wr_data = 8'(CLEAR_VAL);
		end else if (cmd.mem_wr_mark) begin
			wr_en = mark_wr;
		end
	end

	assign rd_en   = cmd.mem_rd_cell || cmd.mem_rd_read;
	assign rd_addr = cmd.mem_rd_read ? AW'(ci_q) : walk_idx;

	lcgr_ram #(
		.WIDTH (lcgr_pkg::CELL_W),
		.DEPTH (NCELLS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// output register
	logic out_valid_q;
	logic ci_ok;

	assign ci_ok = {18'd0, ci_q} < 32'(NCELLS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cell_value    <= '0;
			point_cost    <= '0;
			point_in_grid <= 1'b0;
			case (kind_q)
				lcgr_pkg::KIND_READ: begin
					if (ci_ok) cell_value <= $signed(rd_data);
				end
				lcgr_pkg::KIND_POINT: begin
					point_cost    <= cost_q;
					point_in_grid <= cx_ok && cy_ok;
				end
				default: ;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_busy = out_valid_q && !out_ready;

endmodule

// File: rtl/lcgr_chk.sv
// Port-level checker for the cost grid rasteriser, bound to the top level.
`include "assert_macros.svh"

module lcgr_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [lcgr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [lcgr_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [1:0]                      kind,
	input logic signed [15:0]              point_x,
	input logic signed [15:0]              point_y,
	input logic [13:0]                     cell_index,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic signed [7:0]               cell_value,
	input logic [6:0]                      point_cost,
	input logic                            point_in_grid
);

	`LCGR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cell_value) && $stable(point_cost) && $stable(point_in_grid), "stalled result changed")
	`LCGR_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken while busy")
	`LCGR_ASSERT_IMP(a_read_fields, out_valid && cell_value != 8'sd0, point_cost == 7'd0 && !point_in_grid, "read result carries point fields")
	`LCGR_ASSERT_IMP(a_point_fields, out_valid && (point_in_grid || point_cost != 7'd0), cell_value == 8'sd0, "point result carries cell value")

endmodule

bind lidar_cost_grid_rasterizer_top lcgr_chk u_chk (.*);
